// ===== hdl/ild_pkg.sv =====
package ild_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 4;
  localparam int ModrmW = 3;

  // Primary opcodes that get special handling
  localparam logic [ByteW-1:0] OP_TWO_BYTE  = 8'h0F;
  localparam logic [ByteW-1:0] OP_GRP1_IB   = 8'h83;
  localparam logic [ByteW-1:0] OP_GRP1_ID   = 8'h81;
  localparam logic [ByteW-1:0] OP_IMUL_ID   = 8'h69;
  localparam logic [ByteW-1:0] OP_IMUL_IB   = 8'h6B;
  localparam logic [ByteW-1:0] OP_CALL_REL  = 8'hE8;
  localparam logic [ByteW-1:0] OP_RET_IW    = 8'hC2;
  localparam logic [ByteW-1:0] OP_MOV_R_ID  = 8'hB8;
  localparam logic [ByteW-1:0] OP_POP_RM    = 8'h8F;
  localparam logic [ByteW-1:0] OP_SHIFT_CL  = 8'hD3;

  // Second opcode bytes after 0x0F that carry an imm8
  localparam logic [ByteW-1:0] OP2_SHLD_IB  = 8'hA4;
  localparam logic [ByteW-1:0] OP2_SHRD_IB  = 8'hAC;
  localparam logic [ByteW-1:0] OP2_BT_IB    = 8'hBA;
  localparam logic [ByteW-1:0] OP2_CMP_IB   = 8'hC2;
  localparam logic [ByteW-1:0] OP2_PINSR_IB = 8'hC4;
  localparam logic [ByteW-1:0] OP2_PEXTR_IB = 8'hC5;
  localparam logic [ByteW-1:0] OP2_SHUF_IB  = 8'hC6;

  // Jcc rel32 window of the two-byte map
  localparam logic [ByteW-1:0] OP2_JCC_LO   = 8'h80;
  localparam logic [ByteW-1:0] OP2_JCC_HI   = 8'h8F;

  localparam logic [LenW-1:0] LEN_JCC_REL32 = 4'd6;

  typedef struct packed {
    logic [LenW-1:0] base;        // opcode and immediate bytes
    logic            has_modrm;   // a ModRM byte follows
    logic            modrm_late;  // ModRM sits in the third byte
  } ild_class_t;

endpackage

// ===== hdl/ild_classify.sv =====
module ild_classify
  import ild_pkg::*;
(
  input  logic [ByteW-1:0] opcode_byte,
  input  logic [ByteW-1:0] second_byte,
  output ild_class_t       cls
);

  logic op2_imm8;

  assign op2_imm8 = (second_byte == OP2_SHLD_IB)  || (second_byte == OP2_SHRD_IB) ||
                    (second_byte == OP2_BT_IB)    || (second_byte == OP2_CMP_IB)  ||
                    (second_byte == OP2_PINSR_IB) || (second_byte == OP2_PEXTR_IB) ||
                    (second_byte == OP2_SHUF_IB);

  always_comb begin
    cls.base       = 4'd1;
    cls.has_modrm  = 1'b0;
    cls.modrm_late = 1'b0;
    if ((opcode_byte >= 8'h50 && opcode_byte <= 8'h5F) ||
        opcode_byte == 8'h90 || opcode_byte == 8'hC9 || opcode_byte == 8'hC3 ||
        opcode_byte == 8'hCB || opcode_byte == 8'hCC || opcode_byte == 8'h06 ||
        opcode_byte == 8'h07 || opcode_byte == 8'h0E || opcode_byte == 8'h16 ||
        opcode_byte == 8'h17 || opcode_byte == 8'h1E || opcode_byte == 8'h1F ||
        opcode_byte == 8'h9C || opcode_byte == 8'h9D || opcode_byte == 8'h60 ||
        opcode_byte == 8'h61 || (opcode_byte >= 8'hF8 && opcode_byte <= 8'hFB)) begin
      cls.base = 4'd1;
    end else if ((opcode_byte >= 8'h70 && opcode_byte <= 8'h7F) ||
                 opcode_byte == 8'hEB || (opcode_byte >= 8'hE0 && opcode_byte <= 8'hE3) ||
                 opcode_byte == 8'h6A || (opcode_byte >= 8'hB0 && opcode_byte <= 8'hB7)) begin
      cls.base = 4'd2;
    end else if (opcode_byte == OP_RET_IW || opcode_byte == 8'hCA) begin
      cls.base = 4'd3;
    end else if (opcode_byte == OP_CALL_REL || opcode_byte == 8'hE9 ||
                 opcode_byte == 8'h68 || (opcode_byte >= 8'hA0 && opcode_byte <= 8'hA3) ||
                 opcode_byte >= OP_MOV_R_ID && opcode_byte <= 8'hBF) begin
      cls.base = 4'd5;
    end else if (opcode_byte == 8'h85 || opcode_byte == 8'h87 ||
                 (opcode_byte <= 8'h3B && opcode_byte[7:6] == 2'b00 &&
                  opcode_byte[2:0] != 3'd0 && opcode_byte[2:0] != 3'd2 &&
                  opcode_byte[2] == 1'b0 && opcode_byte[0] == 1'b1 &&
                  opcode_byte[5:3] != 3'd0 || opcode_byte == 8'h01 ||
                  opcode_byte == 8'h03) ||
                 opcode_byte == 8'h89 || opcode_byte == 8'h8B || opcode_byte == 8'h8D ||
                 opcode_byte == OP_POP_RM || opcode_byte == 8'hFF ||
                 opcode_byte == OP_SHIFT_CL) begin
      cls.base      = 4'd1;
      cls.has_modrm = 1'b1;
    end else if (opcode_byte == OP_GRP1_IB || opcode_byte == 8'h80 ||
                 opcode_byte == 8'hC0 || opcode_byte == 8'hC1 || opcode_byte == 8'hD0 ||
                 opcode_byte == 8'hD1 || opcode_byte == OP_IMUL_IB) begin
      cls.base      = 4'd2;
      cls.has_modrm = 1'b1;
    end else if (opcode_byte == OP_GRP1_ID || opcode_byte == OP_IMUL_ID) begin
      cls.base      = 4'd5;
      cls.has_modrm = 1'b1;
    end else if (opcode_byte == OP_TWO_BYTE) begin
      if (second_byte >= OP2_JCC_LO && second_byte <= OP2_JCC_HI) begin
        cls.base = LEN_JCC_REL32;
      end else begin
        cls.base       = op2_imm8 ? 4'd3 : 4'd2;
        cls.has_modrm  = 1'b1;
        cls.modrm_late = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ild_length.sv =====
module ild_length
  import ild_pkg::*;
(
  input  ild_class_t       cls,
  input  logic [ByteW-1:0] second_byte,
  input  logic [ByteW-1:0] third_byte,
  input  logic [ByteW-1:0] fourth_byte,
  output logic [LenW-1:0]  length_bytes
);

  logic [ByteW-1:0]   modrm;
  logic [ByteW-1:0]   sib;
  logic [1:0]         mod_f;
  logic [2:0]         rm_f;
  logic [ModrmW-1:0]  addr_bytes;

  assign modrm = cls.modrm_late ? third_byte : second_byte;
  assign sib   = cls.modrm_late ? fourth_byte : third_byte;
  assign mod_f = modrm[7:6];
  assign rm_f  = modrm[2:0];

  // ModRM byte, optional SIB, optional displacement
  always_comb begin
    addr_bytes = 3'd1;
    if (mod_f != 2'd3) begin
      if (rm_f == 3'd4) begin
        addr_bytes = addr_bytes + 3'd1;
        if (mod_f == 2'd0 && sib[2:0] == 3'd5) addr_bytes = addr_bytes + 3'd4;
      end
      if (mod_f == 2'd1) begin
        addr_bytes = addr_bytes + 3'd1;
      end else if (mod_f == 2'd2) begin
        addr_bytes = addr_bytes + 3'd4;
      end else if (rm_f == 3'd5) begin
        addr_bytes = addr_bytes + 3'd4;
      end
    end
  end

  assign length_bytes = cls.base + (cls.has_modrm ? {1'b0, addr_bytes} : {LenW{1'b0}});

endmodule

// ===== hdl/x86_instruction_length_decoder_core.sv =====
// Length decoder for 32-bit x86 instructions without prefixes. Present the
// first four instruction bytes with start; busy stays low, so a request is
// taken on every cycle that start is high. Each request yields exactly one
// length_bytes value (1..11), shown for one cycle with done high; the
// receiver cannot stall, so capture it on that cycle. The result passes
// through the input register and the result register around one pass of
// opcode classification and ModRM/SIB/displacement counting; throughput is
// one request per cycle. Unknown opcodes decode as length 1.
module x86_instruction_length_decoder_core
  import ild_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [ByteW-1:0] opcode_byte,
  input  logic [ByteW-1:0] second_byte,
  input  logic [ByteW-1:0] third_byte,
  input  logic [ByteW-1:0] fourth_byte,
  output logic             done,
  output logic [LenW-1:0]  length_bytes
);

  // Input register stage
  logic             in_valid;
  logic [ByteW-1:0] in_op;
  logic [ByteW-1:0] in_b1;
  logic [ByteW-1:0] in_b2;
  logic [ByteW-1:0] in_b3;

  ild_class_t       cls;
  logic [LenW-1:0]  length_next;

  // No stall source anywhere: always ready for the next request
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  // Payload: capture every cycle, qualified by the valid bits above
  always_ff @(posedge clk) begin
    in_op        <= opcode_byte;
    in_b1        <= second_byte;
    in_b2        <= third_byte;
    in_b3        <= fourth_byte;
    length_bytes <= length_next;
  end

  // Sort the opcode into its length group
  ild_classify u_classify (
    .opcode_byte (in_op),
    .second_byte (in_b1),
    .cls         (cls)
  );

  // Add ModRM, SIB and displacement bytes to the group's base length
  ild_length u_length (
    .cls          (cls),
    .second_byte  (in_b1),
    .third_byte   (in_b2),
    .fourth_byte  (in_b3),
    .length_bytes (length_next)
  );

endmodule

// ===== hdl/ild_checker.sv =====
module ild_checker
  import ild_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [ByteW-1:0] opcode_byte,
  input logic             done,
  input logic [LenW-1:0]  length_bytes
);

  // Never refuse a request
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Every accepted request yields a result after the input and result registers
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start ##1 !rst) |=> done)
    else $error("request lost");

  // No result without a matching earlier request and no reset since
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start, 2) && !$past(rst, 1) && !$past(rst, 2)))
    else $error("result without request");

  // Length stays within the legal span
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (length_bytes >= 4'd1 && length_bytes <= 4'd11))
    else $error("length out of range");

  // Near call always decodes as five bytes
  a_call_len: assert property (@(posedge clk) disable iff (rst)
    (done && $past(opcode_byte, 2) == OP_CALL_REL) |-> (length_bytes == 4'd5))
    else $error("call length wrong");

endmodule

bind x86_instruction_length_decoder_core ild_checker u_ild_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode_byte  (opcode_byte),
  .done         (done),
  .length_bytes (length_bytes)
);

// ===== verif/tb.sv =====
module tb;
  import ild_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // ModRM and SIB field codes used by the addressing count
  localparam logic [1:0] MOD_INDIRECT  = 2'd0;
  localparam logic [1:0] MOD_DISP8     = 2'd1;
  localparam logic [1:0] MOD_DISP32    = 2'd2;
  localparam logic [1:0] MOD_REG       = 2'd3;
  localparam logic [2:0] RM_SIB        = 3'd4;
  localparam logic [2:0] RM_DISP32     = 3'd5;
  localparam logic [2:0] SIB_BASE_NONE = 3'd5;

  // Contiguous opcode windows of the one-byte map
  localparam logic [ByteW-1:0] OP_PUSH_POP_LO = 8'h50;
  localparam logic [ByteW-1:0] OP_PUSH_POP_HI = 8'h5F;
  localparam logic [ByteW-1:0] OP_JCC8_LO     = 8'h70;
  localparam logic [ByteW-1:0] OP_JCC8_HI     = 8'h7F;
  localparam logic [ByteW-1:0] OP_LOOP_LO     = 8'hE0;
  localparam logic [ByteW-1:0] OP_LOOP_HI     = 8'hE3;
  localparam logic [ByteW-1:0] OP_MOV_R8_LO   = 8'hB0;
  localparam logic [ByteW-1:0] OP_MOV_R8_HI   = 8'hB7;
  localparam logic [ByteW-1:0] OP_MOV_R_ID_HI = 8'hBF;
  localparam logic [ByteW-1:0] OP_MOFFS_LO    = 8'hA0;
  localparam logic [ByteW-1:0] OP_MOFFS_HI    = 8'hA3;

  // Single opcodes the directed part names
  localparam logic [ByteW-1:0] OP_UNDECODED   = 8'h00;
  localparam logic [ByteW-1:0] OP_GRP5        = 8'hFF;
  localparam logic [ByteW-1:0] OP_MOV_STORE   = 8'h89;
  localparam logic [ByteW-1:0] OP_MOV_LOAD    = 8'h8B;
  localparam logic [ByteW-1:0] OP_MOFFS_STORE = 8'hA2;
  localparam logic [ByteW-1:0] OP2_SETCC      = 8'h90;
  localparam logic [ByteW-1:0] OP2_IMUL_RM    = 8'hAF;

  // Opcode tables, packed one byte per entry
  localparam int TBL_W = 24 * ByteW;
  localparam int N_LEN1 = 20;
  localparam logic [TBL_W-1:0] LEN1_OPS = TBL_W'({
    8'h90, 8'hC9, 8'hC3, 8'hCB, 8'hCC, 8'h06, 8'h07, 8'h0E, 8'h16, 8'h17,
    8'h1E, 8'h1F, 8'h9C, 8'h9D, 8'h60, 8'h61, 8'hF8, 8'hF9, 8'hFA, 8'hFB});
  localparam int N_LEN2 = 2;
  localparam logic [TBL_W-1:0] LEN2_OPS = TBL_W'({8'hEB, 8'h6A});
  localparam int N_LEN3 = 2;
  localparam logic [TBL_W-1:0] LEN3_OPS = TBL_W'({OP_RET_IW, 8'hCA});
  localparam int N_LEN5 = 3;
  localparam logic [TBL_W-1:0] LEN5_OPS = TBL_W'({OP_CALL_REL, 8'hE9, 8'h68});
  localparam int N_RM = 24;
  localparam logic [TBL_W-1:0] RM_OPS = TBL_W'({
    8'h85, 8'h87, 8'h01, 8'h03, 8'h09, 8'h0B, 8'h11, 8'h13, 8'h19, 8'h1B,
    8'h21, 8'h23, 8'h29, 8'h2B, 8'h31, 8'h33, 8'h39, 8'h3B, OP_MOV_STORE,
    OP_MOV_LOAD, 8'h8D, OP_POP_RM, OP_GRP5, OP_SHIFT_CL});
  localparam int N_RM_IB = 7;
  localparam logic [TBL_W-1:0] RM_IB_OPS = TBL_W'({
    OP_GRP1_IB, 8'h80, 8'hC0, 8'hC1, 8'hD0, 8'hD1, OP_IMUL_IB});
  localparam int N_RM_ID = 2;
  localparam logic [TBL_W-1:0] RM_ID_OPS = TBL_W'({OP_GRP1_ID, OP_IMUL_ID});
  localparam int N_OP2_IB = 7;
  localparam logic [TBL_W-1:0] OP2_IB_OPS = TBL_W'({
    OP2_SHLD_IB, OP2_SHRD_IB, OP2_BT_IB, OP2_CMP_IB, OP2_PINSR_IB,
    OP2_PEXTR_IB, OP2_SHUF_IB});

  localparam int RANDOM_PER_PHASE = 500;

  typedef struct {
    logic [ByteW-1:0] opcode;
    logic [ByteW-1:0] second;
    logic [ByteW-1:0] third;
    logic [ByteW-1:0] fourth;
    int               idle_pct;   // chance in a hundred that the sender idles
    bit               drain;      // hold off until no length is outstanding
  } instr_req_t;

  typedef struct {
    logic [ByteW-1:0] opcode;
    logic [ByteW-1:0] second;
    logic [ByteW-1:0] third;
    logic [ByteW-1:0] fourth;
    logic [LenW-1:0]  length;
  } length_exp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [ByteW-1:0] opcode_byte = '0;
  logic [ByteW-1:0] second_byte = '0;
  logic [ByteW-1:0] third_byte = '0;
  logic [ByteW-1:0] fourth_byte = '0;
  logic             done;
  logic [LenW-1:0]  length_bytes;

  instr_req_t  instr_q[$];     // requests not yet taken by the decoder
  length_exp_t length_q[$];    // lengths owed by the decoder, oldest first
  bit          taken = 1'b0;   // a request was taken at the last rising edge
  int          cur_idle = 0;
  bit          drain_next = 1'b0;
  int          errors = 0;
  int          n_checked = 0;
  int          n_two_byte = 0;
  int          longest = 0;
  length_exp_t exp_len;
  length_exp_t new_exp;

  x86_instruction_length_decoder_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode_byte  (opcode_byte),
    .second_byte  (second_byte),
    .third_byte   (third_byte),
    .fourth_byte  (fourth_byte),
    .done         (done),
    .length_bytes (length_bytes)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hold reset from time zero, then release it for good.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: end a hung run.
  initial begin
    #500000;
    $display("%0t ns: timeout with %0d requests and %0d lengths outstanding",
             $time, instr_q.size(), length_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit listed(input logic [ByteW-1:0] op, input logic [TBL_W-1:0] tbl,
                                input int n);
    for (int i = 0; i < n; i++)
      if (tbl[i*ByteW +: ByteW] == op) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [ByteW-1:0] pick(input logic [TBL_W-1:0] tbl, input int n);
    int idx;
    idx = int'($urandom_range(n - 1));
    return tbl[idx*ByteW +: ByteW];
  endfunction

  function automatic bit in_window(input logic [ByteW-1:0] op, input logic [ByteW-1:0] lo,
                                   input logic [ByteW-1:0] hi);
    return op >= lo && op <= hi;
  endfunction

  // Count the ModRM byte, an optional SIB byte and the displacement.
  function automatic logic [LenW-1:0] addr_bytes(input logic [ByteW-1:0] modrm,
                                                 input logic [ByteW-1:0] sib);
    logic [1:0]      md;
    logic [2:0]      rm;
    logic [LenW-1:0] n;
    md = modrm[7:6];
    rm = modrm[2:0];
    n  = 4'd1;
    if (md == MOD_REG) return n;
    if (rm == RM_SIB) begin
      n = n + 4'd1;
      // SIB with no base register carries its own 32-bit displacement
      if (md == MOD_INDIRECT && sib[2:0] == SIB_BASE_NONE) n = n + 4'd4;
    end
    if (md == MOD_DISP8) n = n + 4'd1;
    else if (md == MOD_DISP32) n = n + 4'd4;
    else if (rm == RM_DISP32) n = n + 4'd4;
    return n;
  endfunction

  function automatic logic [LenW-1:0] instr_length(input logic [ByteW-1:0] op,
                                                   input logic [ByteW-1:0] b1,
                                                   input logic [ByteW-1:0] b2,
                                                   input logic [ByteW-1:0] b3);
    logic [LenW-1:0] n;
    if (in_window(op, OP_PUSH_POP_LO, OP_PUSH_POP_HI) || listed(op, LEN1_OPS, N_LEN1))
      return 4'd1;
    if (in_window(op, OP_JCC8_LO, OP_JCC8_HI) || in_window(op, OP_LOOP_LO, OP_LOOP_HI) ||
        in_window(op, OP_MOV_R8_LO, OP_MOV_R8_HI) || listed(op, LEN2_OPS, N_LEN2))
      return 4'd2;
    if (listed(op, LEN3_OPS, N_LEN3)) return 4'd3;
    if (listed(op, LEN5_OPS, N_LEN5) || in_window(op, OP_MOFFS_LO, OP_MOFFS_HI) ||
        in_window(op, OP_MOV_R_ID, OP_MOV_R_ID_HI))
      return 4'd5;
    if (listed(op, RM_OPS, N_RM)) return 4'd1 + addr_bytes(b1, b2);
    if (listed(op, RM_IB_OPS, N_RM_IB)) return 4'd2 + addr_bytes(b1, b2);
    if (listed(op, RM_ID_OPS, N_RM_ID)) return 4'd5 + addr_bytes(b1, b2);
    if (op == OP_TWO_BYTE) begin
      if (in_window(b1, OP2_JCC_LO, OP2_JCC_HI)) return LEN_JCC_REL32;
      n = 4'd2 + addr_bytes(b2, b3);
      if (listed(b1, OP2_IB_OPS, N_OP2_IB)) n = n + 4'd1;
      return n;
    end
    // anything else decodes as a single byte
    return 4'd1;
  endfunction

  task automatic add_req(input logic [ByteW-1:0] op, input logic [ByteW-1:0] b1,
                         input logic [ByteW-1:0] b2, input logic [ByteW-1:0] b3);
    instr_req_t r;
    r.opcode   = op;
    r.second   = b1;
    r.third    = b2;
    r.fourth   = b3;
    r.idle_pct = cur_idle;
    r.drain    = drain_next;
    drain_next = 1'b0;
    instr_q.push_back(r);
  endtask

  // Steer a random ModRM/SIB pair toward the SIB and disp32 forms.
  task automatic shape_addr(inout logic [ByteW-1:0] modrm, inout logic [ByteW-1:0] sib);
    if ($urandom_range(1)) begin
      modrm[2:0] = RM_SIB;
      if (modrm[7:6] == MOD_REG) modrm[7:6] = 2'($urandom_range(2));
      if ($urandom_range(1)) sib[2:0] = SIB_BASE_NONE;
    end else if ($urandom_range(3) == 0) begin
      modrm = {MOD_INDIRECT, modrm[5:3], RM_DISP32};
    end
  endtask

  task automatic add_random_instr();
    logic [ByteW-1:0] op, b1, b2, b3;
    op = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    b3 = 8'($urandom);
    case ($urandom_range(9))
      0, 1: ;  // raw bytes: noise and undecoded opcodes
      2: op = pick(LEN1_OPS, N_LEN1);
      3: begin
        case ($urandom_range(7))
          0: op = pick(LEN2_OPS, N_LEN2);
          1: op = pick(LEN3_OPS, N_LEN3);
          2: op = pick(LEN5_OPS, N_LEN5);
          3: op = 8'($urandom_range(OP_PUSH_POP_HI, OP_PUSH_POP_LO));
          4: op = 8'($urandom_range(OP_JCC8_HI, OP_JCC8_LO));
          5: op = 8'($urandom_range(OP_LOOP_HI, OP_LOOP_LO));
          6: op = 8'($urandom_range(OP_MOFFS_HI, OP_MOFFS_LO));
          default: op = 8'($urandom_range(OP_MOV_R_ID_HI, OP_MOV_R8_LO));
        endcase
      end
      4, 5: begin
        op = pick(RM_OPS, N_RM);
        shape_addr(b1, b2);
      end
      6: begin
        op = pick(RM_IB_OPS, N_RM_IB);
        shape_addr(b1, b2);
      end
      7: begin
        op = pick(RM_ID_OPS, N_RM_ID);
        shape_addr(b1, b2);
      end
      default: begin
        op = OP_TWO_BYTE;
        case ($urandom_range(2))
          0: b1 = 8'($urandom_range(OP2_JCC_HI, OP2_JCC_LO));
          1: b1 = pick(OP2_IB_OPS, N_OP2_IB);
          default: ;
        endcase
        shape_addr(b2, b3);
      end
    endcase
    add_req(op, b1, b2, b3);
  endtask

  // Monitor: check a finished length, then log a newly taken request.
  always @(posedge clk) begin
    taken = !rst && start && !busy;
    if (!rst && done === 1'b1) begin
      if (length_q.size() == 0) begin
        errors++;
        $display("%0t ns: length %0d reported with no request outstanding",
                 $time, length_bytes);
      end else begin
        exp_len = length_q.pop_front();
        n_checked++;
        if (length_bytes !== exp_len.length) begin
          errors++;
          $display("%0t ns: length of %h %h %h %h: expected %0d, got %0d", $time,
                   exp_len.opcode, exp_len.second, exp_len.third, exp_len.fourth,
                   exp_len.length, length_bytes);
        end
      end
    end
    if (taken) begin
      new_exp.opcode = opcode_byte;
      new_exp.second = second_byte;
      new_exp.third  = third_byte;
      new_exp.fourth = fourth_byte;
      new_exp.length = instr_length(opcode_byte, second_byte, third_byte, fourth_byte);
      if (opcode_byte == OP_TWO_BYTE) n_two_byte++;
      if (int'(new_exp.length) > longest) longest = int'(new_exp.length);
      length_q.push_back(new_exp);
    end
  end

  // Driver: retire the request taken at the last edge, then offer the next
  // one or idle with junk on the byte lanes.
  always @(negedge clk) begin
    if (!rst) begin
      if (taken) instr_q.delete(0);
      if (instr_q.size() != 0 && !(instr_q[0].drain && length_q.size() != 0) &&
          $urandom_range(99) >= instr_q[0].idle_pct) begin
        start       <= 1'b1;
        opcode_byte <= instr_q[0].opcode;
        second_byte <= instr_q[0].second;
        third_byte  <= instr_q[0].third;
        fourth_byte <= instr_q[0].fourth;
      end else begin
        start       <= 1'b0;
        opcode_byte <= 8'($urandom);
        second_byte <= 8'($urandom);
        third_byte  <= 8'($urandom);
        fourth_byte <= 8'($urandom);
      end
    end
  end

  initial begin
    // Directed: field extremes, each length group and the addressing corners.
    add_req(OP_UNDECODED, '0, '0, '0);
    add_req(OP_GRP5, '1, '1, '1);
    add_req(OP_PUSH_POP_HI, '1, '0, '1);
    add_req(OP_JCC8_LO, '0, '1, '0);
    add_req(OP_RET_IW, 8'h10, 8'h00, 8'hFF);
    add_req(OP_CALL_REL, '1, '1, '1);
    add_req(OP_MOFFS_LO, '0, '0, '0);
    add_req(OP_MOFFS_STORE, '1, '0, '0);
    add_req(OP_MOV_R_ID_HI, '0, '1, '0);
    add_req(OP_MOV_STORE, {MOD_INDIRECT, 3'd0, RM_DISP32}, '1, '1);
    add_req(OP_MOV_LOAD, {MOD_INDIRECT, 3'd1, RM_SIB}, {2'd0, 3'd4, SIB_BASE_NONE}, '0);
    add_req(OP_MOV_LOAD, {MOD_INDIRECT, 3'd1, RM_SIB}, {2'd3, 3'd4, 3'd4}, '0);
    add_req(OP_POP_RM, {MOD_DISP8, 3'd0, RM_SIB}, {2'd1, 3'd2, SIB_BASE_NONE}, '1);
    add_req(OP_SHIFT_CL, {MOD_DISP32, 3'd4, RM_SIB}, {2'd2, 3'd7, SIB_BASE_NONE}, '0);
    // no SIB byte with a register operand: the third byte is ignored
    add_req(OP_MOV_LOAD, {MOD_REG, 3'd0, RM_SIB}, {2'd0, 3'd0, SIB_BASE_NONE}, '1);
    add_req(OP_GRP1_IB, {MOD_DISP8, 3'd7, RM_DISP32}, '0, '0);
    add_req(OP_GRP1_ID, {MOD_INDIRECT, 3'd0, RM_SIB}, {2'd0, 3'd0, SIB_BASE_NONE}, '1);
    add_req(OP_IMUL_ID, {MOD_REG, 3'd0, 3'd0}, '1, '1);
    add_req(OP_IMUL_IB, {MOD_DISP32, 3'd2, RM_DISP32}, '0, '1);
    add_req(OP_TWO_BYTE, OP2_JCC_LO, '1, '1);
    add_req(OP_TWO_BYTE, OP2_JCC_HI, '0, '0);
    add_req(OP_TWO_BYTE, OP2_SHLD_IB, {MOD_INDIRECT, 3'd0, RM_SIB},
            {2'd0, 3'd0, SIB_BASE_NONE});
    add_req(OP_TWO_BYTE, OP2_SHUF_IB, {MOD_INDIRECT, 3'd2, RM_DISP32}, '1);
    add_req(OP_TWO_BYTE, OP2_BT_IB, {MOD_DISP8, 3'd4, RM_SIB}, '1);
    add_req(OP_TWO_BYTE, OP2_SETCC, {MOD_REG, 3'd0, RM_SIB}, {2'd0, 3'd0, SIB_BASE_NONE});
    add_req(OP_TWO_BYTE, OP2_IMUL_RM, {MOD_DISP32, 3'd1, 3'd3}, '0);

    // Random phases: no idling, heavy idling, no idling, light idling.
    // Drain the pipe before each phase starts.
    for (int p = 0; p < 4; p++) begin
      cur_idle   = (p == 1) ? 58 : (p == 3) ? 18 : 0;
      drain_next = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) add_random_instr();
    end

    // Advance until every request is taken and every length is back.
    while (instr_q.size() != 0 || length_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d decoded lengths (%0d two-byte opcodes, longest %0d bytes)",
             n_checked, n_two_byte, longest);
    $display("across four idling phases with a pipeline drain before each.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
